/* hdl/olc_pkg.sv */
// Shared constants, types and word helpers for the ordered list block.
`default_nettype none

package olc_pkg;

   localparam int CAPACITY   = 64;
   localparam int WORD_WIDTH = 32;

   localparam int ACT_W  = 4;
   localparam int POS_W  = 7;
   localparam int VAL_W  = 32;
   localparam int RSP_W  = 32;
   localparam int STAT_W = 3;
   localparam int LEN_W  = 7;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

   localparam logic [ACT_W-1:0] ACT_INS_IDX   = 4'd0;
   localparam logic [ACT_W-1:0] ACT_INS_FIRST = 4'd1;
   localparam logic [ACT_W-1:0] ACT_INS_LAST  = 4'd2;
   localparam logic [ACT_W-1:0] ACT_RM_IDX    = 4'd3;
   localparam logic [ACT_W-1:0] ACT_RM_FIRST  = 4'd4;
   localparam logic [ACT_W-1:0] ACT_RM_LAST   = 4'd5;
   localparam logic [ACT_W-1:0] ACT_RD_IDX    = 4'd6;
   localparam logic [ACT_W-1:0] ACT_RD_FIRST  = 4'd7;
   localparam logic [ACT_W-1:0] ACT_RD_LAST   = 4'd8;
   localparam logic [ACT_W-1:0] ACT_CUR_RST   = 4'd9;
   localparam logic [ACT_W-1:0] ACT_CUR_NEXT  = 4'd10;
   localparam logic [ACT_W-1:0] ACT_CUR_PREV  = 4'd11;
   localparam logic [ACT_W-1:0] ACT_CUR_RD    = 4'd12;

   localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
   localparam logic [STAT_W-1:0] ST_INDEX = 3'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 3'd2;
   localparam logic [STAT_W-1:0] ST_NULL  = 3'd3;
   localparam logic [STAT_W-1:0] ST_END   = 3'd4;
   localparam logic [STAT_W-1:0] ST_FULL  = 3'd5;

   typedef enum logic [1:0] {
      SOP_RD,
      SOP_INS,
      SOP_DEL
   } sop_type;

   // request from the command sequencer to the storage engine
   typedef struct packed {
      logic                  start;
      sop_type               op;
      logic [IDX_W-1:0]      addr;
      logic [CNT_W-1:0]      cnt;
      logic [WORD_WIDTH-1:0] data;
   } st_cmd_type;

   typedef struct packed {
      logic                  done;
      logic [WORD_WIDTH-1:0] rdata;
   } st_rsp_type;

   // incoming word is taken unsigned, then cut to the stored width
   function automatic logic [WORD_WIDTH-1:0] fit_word(input logic [VAL_W-1:0] v);
      logic [63:0] z;
      z = 64'(v);
      return z[WORD_WIDTH-1:0];
   endfunction

   // stored word sign-extended from its top bit, then cut to the result width
   function automatic logic signed [RSP_W-1:0] to_rsp(input logic [WORD_WIDTH-1:0] w);
      logic signed [63:0] e;
      e = 64'(signed'(w));
      return e[RSP_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* hdl/olc_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module olc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/olc_store.sv */
// Storage engine: entry RAM plus the stepping address unit that shifts entries.
`default_nettype none

module olc_store
   import olc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire st_cmd_type cmd,
   output st_rsp_type      rsp
);

   typedef enum logic [1:0] {
      SS_IDLE,
      SS_SHIFT,
      SS_READ
   } sstate_type;

   sstate_type            state_ff, state_in;
   logic                  ins_ff, ins_in;
   logic [IDX_W-1:0]      src_ff, src_in;
   logic [CNT_W-1:0]      left_ff, left_in;
   logic                  pend_ff, pend_in;
   logic [IDX_W-1:0]      pend_addr_ff, pend_addr_in;
   logic [IDX_W-1:0]      addr_ff, addr_in;
   logic [WORD_WIDTH-1:0] data_ff, data_in;

   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   logic [WORD_WIDTH-1:0] ram_wr_data;
   logic [IDX_W-1:0]      ram_rd_addr;
   logic [WORD_WIDTH-1:0] ram_rd_data;
   logic                  done;

   olc_ram #(
      .WIDTH(WORD_WIDTH),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // read of step k lands as the write of step k+1
   always_comb begin
      state_in     = state_ff;
      ins_in       = ins_ff;
      src_in       = src_ff;
      left_in      = left_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      addr_in      = addr_ff;
      data_in      = data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = pend_addr_ff;
      ram_wr_data  = ram_rd_data;
      ram_rd_addr  = src_ff;
      done         = 1'b0;
      case (state_ff)
         SS_IDLE: begin
            ram_rd_addr = cmd.addr;
            if (cmd.start) begin
               addr_in = cmd.addr;
               data_in = cmd.data;
               case (cmd.op)
                  SOP_INS: begin
                     ins_in   = 1'b1;
                     src_in   = IDX_W'(cmd.cnt - CNT_W'(1));
                     left_in  = cmd.cnt - CNT_W'(cmd.addr);
                     state_in = SS_SHIFT;
                  end
                  SOP_DEL: begin
                     ins_in   = 1'b0;
                     src_in   = IDX_W'(CNT_W'(cmd.addr) + CNT_W'(1));
                     left_in  = cmd.cnt - CNT_W'(1) - CNT_W'(cmd.addr);
                     state_in = SS_SHIFT;
                  end
                  default: begin
                     state_in = SS_READ;
                  end
               endcase
            end
         end
         SS_SHIFT: begin
            if (left_ff != '0) begin
               src_in       = ins_ff ? src_ff - IDX_W'(1) : src_ff + IDX_W'(1);
               left_in      = left_ff - CNT_W'(1);
               pend_in      = 1'b1;
               pend_addr_in = ins_ff ? src_ff + IDX_W'(1) : src_ff - IDX_W'(1);
            end
            if (pend_ff) begin
               ram_wr_en = 1'b1;
            end else if (left_ff == '0) begin
               // moves drained; an insert drops its word into the gap
               if (ins_ff) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = addr_ff;
                  ram_wr_data = data_ff;
               end
               done     = 1'b1;
               state_in = SS_IDLE;
            end
         end
         SS_READ: begin
            done     = 1'b1;
            state_in = SS_IDLE;
         end
         default: begin
            state_in = SS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SS_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
      ins_ff       <= ins_in;
      src_ff       <= src_in;
      left_ff      <= left_in;
      pend_addr_ff <= pend_addr_in;
      addr_ff      <= addr_in;
      data_ff      <= data_in;
   end

   assign rsp.done  = done;
   assign rsp.rdata = ram_rd_data;

endmodule

`default_nettype wire

/* hdl/ordered_list_with_cursor.sv */
// Top level: command sequencer, list length and cursor, result register.
//
//   channel  dir  handshake          fields
//   req_     in   req_valid/stall    action[3:0] position[6:0] value_in[31:0]
//   rsp_     out  rsp_valid/stall    read_value[31:0] status[2:0] length[6:0]
//
// Cursor commands and failed checks pass from accept through execute to the result
// register; reads, inserts and removes also wait in S_WAIT on the storage engine,
// which moves one entry per cycle through the single RAM read/write port pair,
// then drains the last move and drops in the new word (an insert at p moves entries
// p up, a remove those after p). The longest are an insert at the front of a list
// one short of full and a remove at the front of a full list.
// Synchronous reset empties the list and clears the cursor at once; no RAM sweep.
// req_stall is high while a command is in flight. A finished result waits in the
// output register under rsp_stall, and the next word is still taken meanwhile.
`default_nettype none

module ordered_list_with_cursor
   import olc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic        [ACT_W-1:0]  req_action,
   input  wire logic        [POS_W-1:0]  req_position,
   input  wire logic signed [VAL_W-1:0]  req_value_in,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed      [RSP_W-1:0]  rsp_read_value,
   output logic             [STAT_W-1:0] rsp_status,
   output logic             [LEN_W-1:0]  rsp_length
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_WAIT,
      S_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [ACT_W-1:0]        act_ff, act_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [WORD_WIDTH-1:0]   val_ff, val_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        cur_idx_ff, cur_idx_in;
   logic                    cur_vld_ff, cur_vld_in;
   logic                    rd_op_ff, rd_op_in;
   logic signed [RSP_W-1:0] res_rd_ff, res_rd_in;
   logic [STAT_W-1:0]       res_st_ff, res_st_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [RSP_W-1:0] rsp_rd_ff, rsp_rd_in;
   logic [STAT_W-1:0]       rsp_st_ff, rsp_st_in;
   logic [LEN_W-1:0]        rsp_len_ff, rsp_len_in;

   st_cmd_type              scmd;
   st_rsp_type              srsp;

   // decode helpers
   logic [CMP_W-1:0]        pos_w, cnt_w;
   logic                    full, empty;
   logic [IDX_W-1:0]        last_idx;
   logic [IDX_W-1:0]        ins_p, rm_p, rd_a;
   logic [IDX_W-1:0]        ins_cur_idx, rm_idx;
   logic                    rm_vld, rm_last;
   logic                    do_ins, do_rm, do_rd;

   olc_store u_store (
      .clock(clock),
      .reset(reset),
      .cmd  (scmd),
      .rsp  (srsp)
   );

   assign pos_w    = CMP_W'(pos_ff);
   assign cnt_w    = CMP_W'(count_ff);
   assign full     = (count_ff >= CNT_W'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign last_idx = IDX_W'(count_ff - CNT_W'(1));

   // insert point and cursor after an insert
   always_comb begin
      case (act_ff)
         ACT_INS_IDX:   ins_p = IDX_W'(pos_ff);
         ACT_INS_FIRST: ins_p = '0;
         default:       ins_p = IDX_W'(count_ff);
      endcase
      ins_cur_idx = (cur_vld_ff && cur_idx_ff >= ins_p) ? cur_idx_ff + IDX_W'(1)
                                                        : cur_idx_ff;
   end

   // remove point and cursor after a remove
   always_comb begin
      case (act_ff)
         ACT_RM_IDX:   rm_p = IDX_W'(pos_ff);
         ACT_RM_FIRST: rm_p = '0;
         default:      rm_p = last_idx;
      endcase
      rm_last = (rm_p == last_idx);
      rm_vld  = cur_vld_ff;
      rm_idx  = cur_idx_ff;
      if (act_ff == ACT_RM_IDX && rm_last && cur_vld_ff && cur_idx_ff == rm_p) begin
         // indexed remove of the tail under the cursor: cursor goes null
         rm_vld = 1'b0;
         rm_idx = '0;
      end else if (cur_vld_ff) begin
         if (cur_idx_ff == rm_p) begin
            // tail steps back, any other entry hands over to its follower
            if (rm_last) begin
               if (rm_p == '0) begin
                  rm_vld = 1'b0;
               end else begin
                  rm_idx = rm_p - IDX_W'(1);
               end
            end
         end else if (cur_idx_ff > rm_p) begin
            rm_idx = cur_idx_ff - IDX_W'(1);
         end
      end
      if (count_ff == CNT_W'(1)) begin
         rm_vld = 1'b0;
         rm_idx = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      count_in     = count_ff;
      cur_idx_in   = cur_idx_ff;
      cur_vld_in   = cur_vld_ff;
      rd_op_in     = rd_op_ff;
      res_rd_in    = res_rd_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_rd_in    = rsp_rd_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_len_in   = rsp_len_ff;
      do_ins       = 1'b0;
      do_rm        = 1'b0;
      do_rd        = 1'b0;
      rd_a         = '0;
      scmd.start   = 1'b0;
      scmd.op      = SOP_RD;
      scmd.addr    = '0;
      scmd.cnt     = count_ff;
      scmd.data    = val_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in   = req_action;
               pos_in   = req_position;
               val_in   = fit_word(req_value_in);
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_rd_in = '0;
            res_st_in = ST_OK;
            rd_op_in  = 1'b0;
            state_in  = S_DONE;
            case (act_ff)
               ACT_INS_IDX: begin
                  if (pos_w > cnt_w) begin
                     res_st_in = ST_INDEX;
                  end else if (full) begin
                     res_st_in = ST_FULL;
                  end else begin
                     do_ins = 1'b1;
                  end
               end
               ACT_INS_FIRST, ACT_INS_LAST: begin
                  if (full) begin
                     res_st_in = ST_FULL;
                  end else begin
                     do_ins = 1'b1;
                  end
               end
               ACT_RM_IDX: begin
                  if (pos_w >= cnt_w) begin
                     res_st_in = ST_INDEX;
                  end else begin
                     do_rm = 1'b1;
                  end
               end
               ACT_RM_FIRST, ACT_RM_LAST: begin
                  if (empty) begin
                     res_st_in = ST_EMPTY;
                  end else begin
                     do_rm = 1'b1;
                  end
               end
               ACT_RD_IDX: begin
                  if (pos_w >= cnt_w) begin
                     res_st_in = ST_INDEX;
                     res_rd_in = '1;
                  end else begin
                     do_rd = 1'b1;
                     rd_a  = IDX_W'(pos_ff);
                  end
               end
               ACT_RD_FIRST, ACT_RD_LAST: begin
                  if (empty) begin
                     res_st_in = ST_EMPTY;
                     res_rd_in = '1;
                  end else begin
                     do_rd = 1'b1;
                     rd_a  = (act_ff == ACT_RD_FIRST) ? '0 : last_idx;
                  end
               end
               ACT_CUR_RST: begin
                  cur_idx_in = '0;
                  if (empty) begin
                     cur_vld_in = 1'b0;
                     res_st_in  = ST_EMPTY;
                  end else begin
                     cur_vld_in = 1'b1;
                  end
               end
               ACT_CUR_NEXT: begin
                  if (!cur_vld_ff) begin
                     res_st_in = ST_NULL;
                  end else if (CNT_W'(cur_idx_ff) + CNT_W'(1) >= count_ff) begin
                     res_st_in = ST_END;
                  end else begin
                     cur_idx_in = cur_idx_ff + IDX_W'(1);
                  end
               end
               ACT_CUR_PREV: begin
                  if (!cur_vld_ff) begin
                     res_st_in = ST_NULL;
                  end else if (cur_idx_ff == '0) begin
                     res_st_in = ST_END;
                  end else begin
                     cur_idx_in = cur_idx_ff - IDX_W'(1);
                  end
               end
               ACT_CUR_RD: begin
                  if (!cur_vld_ff || CNT_W'(cur_idx_ff) >= count_ff) begin
                     res_st_in = ST_NULL;
                     res_rd_in = '1;
                  end else begin
                     do_rd = 1'b1;
                     rd_a  = cur_idx_ff;
                  end
               end
               default: begin
               end
            endcase
            // length and cursor settle now; the store works from the old count
            if (do_ins) begin
               count_in   = count_ff + CNT_W'(1);
               cur_idx_in = ins_cur_idx;
               scmd.start = 1'b1;
               scmd.op    = SOP_INS;
               scmd.addr  = ins_p;
               state_in   = S_WAIT;
            end
            if (do_rm) begin
               count_in   = count_ff - CNT_W'(1);
               cur_vld_in = rm_vld;
               cur_idx_in = rm_idx;
               scmd.start = 1'b1;
               scmd.op    = SOP_DEL;
               scmd.addr  = rm_p;
               state_in   = S_WAIT;
            end
            if (do_rd) begin
               rd_op_in   = 1'b1;
               scmd.start = 1'b1;
               scmd.op    = SOP_RD;
               scmd.addr  = rd_a;
               state_in   = S_WAIT;
            end
         end
         S_WAIT: begin
            if (srsp.done) begin
               if (rd_op_ff) begin
                  res_rd_in = to_rsp(srsp.rdata);
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // output register free or emptying this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_rd_in    = res_rd_ff;
               rsp_st_in    = res_st_ff;
               rsp_len_in   = LEN_W'(count_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cur_idx_ff   <= '0;
         cur_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cur_idx_ff   <= cur_idx_in;
         cur_vld_ff   <= cur_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff    <= act_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      rd_op_ff  <= rd_op_in;
      res_rd_ff <= res_rd_in;
      res_st_ff <= res_st_in;
      rsp_rd_ff <= rsp_rd_in;
      rsp_st_ff <= rsp_st_in;
      rsp_len_ff <= rsp_len_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_rd_ff;
   assign rsp_status     = rsp_st_ff;
   assign rsp_length     = rsp_len_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("list length beyond capacity");

   a_cursor_in_list: assert property (@(posedge clock) disable iff (reset)
      cur_vld_ff |-> (CNT_W'(cur_idx_ff) < count_ff))
      else $error("cursor points past the list");

   a_empty_null: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> !cur_vld_ff)
      else $error("cursor valid on an empty list");

   a_count_in_exec: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> $past(state_ff == S_EXEC))
      else $error("length changed outside command execution");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      srsp.done |-> (state_ff == S_WAIT))
      else $error("store finished with no command waiting");

endmodule

`default_nettype wire
